[rtl/core/robs_pkg.sv]
package robs_pkg;

  localparam int POS_WIDTH_DEF   = 20;
  localparam int DIR_WIDTH_DEF   = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_ONE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_TWO   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_THREE = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF       = 3'd4;

  localparam int QUOT_WIDTH  = 48;
  localparam int T_WIDTH     = 49;
  localparam int DIV_LATENCY = QUOT_WIDTH + 2;

  localparam logic [QUOT_WIDTH-1:0] T_CAP = 48'h8000_0000_0000;
  localparam logic signed [T_WIDTH-1:0] T_OPEN = 49'sh0_8000_0000_0001;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] AX_NONE = 2'd3;

endpackage

[rtl/core/robs_if.sv]
interface robs_ray_if #(
  parameter int POS_WIDTH = robs_pkg::POS_WIDTH_DEF,
  parameter int DIR_WIDTH = robs_pkg::DIR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] ray_origin_x;
  logic signed [POS_WIDTH-1:0] ray_origin_y;
  logic signed [POS_WIDTH-1:0] ray_origin_z;
  logic signed [DIR_WIDTH-1:0] ray_dir_x;
  logic signed [DIR_WIDTH-1:0] ray_dir_y;
  logic signed [DIR_WIDTH-1:0] ray_dir_z;

  modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, input ready);
  modport sink (input valid, ray_origin_x, ray_origin_y, ray_origin_z,
                ray_dir_x, ray_dir_y, ray_dir_z, output ready);
endinterface

interface robs_hit_if #(
  parameter int POS_WIDTH = robs_pkg::POS_WIDTH_DEF,
  parameter int DIR_WIDTH = robs_pkg::DIR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [31:0]                 hit_distance;
  logic signed [DIR_WIDTH-1:0] normal_x;
  logic signed [DIR_WIDTH-1:0] normal_y;
  logic signed [DIR_WIDTH-1:0] normal_z;
  logic signed [POS_WIDTH-1:0] point_x;
  logic signed [POS_WIDTH-1:0] point_y;
  logic signed [POS_WIDTH-1:0] point_z;

  modport source (output valid, hit, hit_distance, normal_x, normal_y, normal_z,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, hit_distance, normal_x, normal_y, normal_z,
                point_x, point_y, point_z, output ready);
endinterface

[rtl/core/robs_slab_div.sv]
module robs_slab_div #(
  parameter int NUM_WIDTH = 40,
  parameter int DEN_WIDTH = 34,
  parameter int SHIFT     = 18
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [NUM_WIDTH-1:0]                num_mag,
  input  logic                                num_neg,
  input  logic [DEN_WIDTH-1:0]                den,
  output logic signed [robs_pkg::T_WIDTH-1:0] quot
);
  import robs_pkg::*;

  localparam int XW  = NUM_WIDTH + SHIFT;
  localparam int DVW = (XW > QUOT_WIDTH) ? XW : QUOT_WIDTH + 1;
  localparam int HW  = DVW - QUOT_WIDTH;
  localparam int CW  = (HW > DEN_WIDTH) ? HW : DEN_WIDTH;

  logic [DVW-1:0] dvd;
  logic [HW-1:0]  hi;
  logic           ovf_in;

  assign dvd    = DVW'(num_mag) << SHIFT;
  assign hi     = dvd[DVW-1:QUOT_WIDTH];
  assign ovf_in = CW'(hi) >= CW'(den);

  logic [DEN_WIDTH-1:0]  rem  [0:QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] low  [0:QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] qb   [0:QUOT_WIDTH];
  logic [DEN_WIDTH-1:0]  dn   [0:QUOT_WIDTH];
  logic                  ovf  [0:QUOT_WIDTH];
  logic                  neg  [0:QUOT_WIDTH];
  logic [DEN_WIDTH:0]    r2   [1:QUOT_WIDTH];
  logic                  ge   [1:QUOT_WIDTH];

  always_comb begin
    for (int k = 1; k <= QUOT_WIDTH; k++) begin
      r2[k] = {rem[k-1], low[k-1][QUOT_WIDTH-1]};
      ge[k] = r2[k] >= {1'b0, dn[k-1]};
    end
  end

  logic [QUOT_WIDTH-1:0] mag;
  assign mag = (ovf[QUOT_WIDTH] || qb[QUOT_WIDTH] > T_CAP) ? T_CAP : qb[QUOT_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ovf_in ? '0 : DEN_WIDTH'(hi);
      low[0] <= dvd[QUOT_WIDTH-1:0];
      qb[0]  <= '0;
      dn[0]  <= den;
      ovf[0] <= ovf_in;
      neg[0] <= num_neg;
      for (int k = 1; k <= QUOT_WIDTH; k++) begin
        rem[k] <= ge[k] ? DEN_WIDTH'(r2[k] - {1'b0, dn[k-1]}) : DEN_WIDTH'(r2[k]);
        low[k] <= low[k-1] << 1;
        qb[k]  <= {qb[k-1][QUOT_WIDTH-2:0], ge[k]};
        dn[k]  <= dn[k-1];
        ovf[k] <= ovf[k-1];
        neg[k] <= neg[k-1];
      end
      quot <= neg[QUOT_WIDTH] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

[rtl/core/ray_oriented_box_slab_test.sv]
// Ray against oriented box, slab test, one ray word per cycle.
// The ray channel takes an origin and a direction; the box (centre, three
// unit axes, half extents) sits in registers written through the plain
// configuration port, which is to be written only while no ray is in flight;
// the user must see to it, as nothing in the block enforces it. Each accepted
// ray word yields exactly one result word on the hit channel, in order: hit
// flag, distance, face normal and hit point, all zero on a miss. There are
// 59 register stages; the largest share of them is the 48-step restoring
// divider pipeline that forms the six slab distances. Throughput is one word
// per cycle while the hit channel is not stalled.
// The whole pipeline advances together. When the receiver holds ready low
// while a result waits, every stage holds and ray ready falls, so nothing is
// lost or repeated.
// Reset clears all stage valid bits and returns the box to the unit cube at
// the origin.
module ray_oriented_box_slab_test #(
  parameter int POS_WIDTH = robs_pkg::POS_WIDTH_DEF,
  parameter int DIR_WIDTH = robs_pkg::DIR_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [robs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [((3*POS_WIDTH > 3*DIR_WIDTH) ? 3*POS_WIDTH : 3*DIR_WIDTH)-1:0] cfg_data,
  robs_ray_if.sink                                ray,
  robs_hit_if.source                              hit_out
);
  import robs_pkg::*;

  localparam int P  = POS_WIDTH;
  localparam int D  = DIR_WIDTH;
  localparam int TS = D - P + 22;
  localparam int OW = P + 1;
  localparam int MW = D + P + 1;
  localparam int EW = D + P + 3;
  localparam int FW = 2 * D + 2;
  localparam int NE = D + P + 4;
  localparam int DL = DIV_LATENCY;
  localparam int PW = 33 + D;
  localparam int SW = ((PW > P) ? PW : P) + 1;
  localparam logic signed [FW-1:0] EPS = FW'(1) << (2 * D - 20);
  localparam logic signed [SW-1:0] PMAX = SW'((64'd1 << (P - 1)) - 64'd1);
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
  localparam logic signed [D-1:0] DMIN = {1'b1, {(D-1){1'b0}}};
  localparam logic signed [D-1:0] DMAXV = {1'b0, {(D-1){1'b1}}};

  logic [3*P-1:0] center;
  logic [3*P-1:0] half;
  logic [3*D-1:0] axis [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      center  <= '0;
      axis[0] <= (3*D)'(1) << (D - 2);
      axis[1] <= (3*D)'(1) << (2 * D - 2);
      axis[2] <= (3*D)'(1) << (3 * D - 2);
      for (int c = 0; c < 3; c++) half[c*P +: P] <= P'(1) << (P - 8);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER:     center  <= cfg_data[3*P-1:0];
        REG_AXIS_ONE:   axis[0] <= cfg_data[3*D-1:0];
        REG_AXIS_TWO:   axis[1] <= cfg_data[3*D-1:0];
        REG_AXIS_THREE: axis[2] <= cfg_data[3*D-1:0];
        REG_HALF:       half    <= cfg_data[3*P-1:0];
        default: ;
      endcase
    end
  end

  logic signed [D-1:0] ax [3][3];
  logic signed [P-1:0] center_f [3];
  logic [P-1:0]        half_f [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      center_f[i] = center[i*P +: P];
      half_f[i]   = half[i*P +: P];
      for (int c = 0; c < 3; c++) ax[i][c] = axis[i][c*D +: D];
    end
  end

  logic en;
  logic v_out;
  assign en        = !v_out || hit_out.ready;
  assign ray.ready = en;

  logic signed [P-1:0] org_in [3];
  logic signed [D-1:0] dir_in [3];
  assign org_in[0] = ray.ray_origin_x;
  assign org_in[1] = ray.ray_origin_y;
  assign org_in[2] = ray.ray_origin_z;
  assign dir_in[0] = ray.ray_dir_x;
  assign dir_in[1] = ray.ray_dir_y;
  assign dir_in[2] = ray.ray_dir_z;

  logic v1, v2, v3, v4;
  logic signed [P-1:0]  org1 [3], org2 [3], org3 [3], org4 [3];
  logic signed [D-1:0]  dir1 [3], dir2 [3], dir3 [3], dir4 [3];
  logic signed [OW-1:0] off1 [3];
  logic signed [MW-1:0] pe2 [3][3];
  logic signed [2*D-1:0] pf2 [3][3];
  logic signed [EW-1:0] e3 [3];
  logic signed [FW-1:0] f3 [3];
  logic signed [NE-1:0] h3 [3];
  logic [NE-1:0]        mag4 [3][2];
  logic                 neg4 [3][2];
  logic [FW-1:0]        den4 [3];
  logic [2:0]           par4, rej4;

  logic signed [NE-1:0] n_a [3][2];
  logic signed [NE-1:0] e_x [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_x[i]    = NE'(e3[i]);
      n_a[i][0] = e_x[i] + h3[i];
      n_a[i][1] = e_x[i] - h3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= ray.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        org1[c] <= org_in[c];
        dir1[c] <= dir_in[c];
        off1[c] <= OW'(center_f[c]) - OW'(org_in[c]);
        org2[c] <= org1[c];
        dir2[c] <= dir1[c];
        org3[c] <= org2[c];
        dir3[c] <= dir2[c];
        org4[c] <= org3[c];
        dir4[c] <= dir3[c];
      end
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          pe2[i][c] <= ax[i][c] * off1[c];
          pf2[i][c] <= ax[i][c] * dir1[c];
        end
        e3[i] <= EW'(pe2[i][0]) + EW'(pe2[i][1]) + EW'(pe2[i][2]);
        f3[i] <= FW'(pf2[i][0]) + FW'(pf2[i][1]) + FW'(pf2[i][2]);
        h3[i] <= NE'(half_f[i]) << (D - 2);
        for (int j = 0; j < 2; j++) begin
          mag4[i][j] <= n_a[i][j][NE-1] ? NE'(-n_a[i][j]) : NE'(n_a[i][j]);
          neg4[i][j] <= n_a[i][j][NE-1] ^ f3[i][FW-1];
        end
        den4[i] <= f3[i][FW-1] ? FW'(-f3[i]) : FW'(f3[i]);
        par4[i] <= (f3[i] <= EPS) && (f3[i] >= -EPS);
        rej4[i] <= (f3[i] <= EPS) && (f3[i] >= -EPS) && (e_x[i] < -h3[i] || e_x[i] > h3[i]);
      end
    end
  end

  logic signed [T_WIDTH-1:0] q [3][2];

  for (genvar gi = 0; gi < 3; gi++) begin : g_axis
    for (genvar gj = 0; gj < 2; gj++) begin : g_side
      robs_slab_div #(
        .NUM_WIDTH (NE),
        .DEN_WIDTH (FW),
        .SHIFT     (TS)
      ) u_div (
        .clk     (clk),
        .en      (en),
        .num_mag (mag4[gi][gj]),
        .num_neg (neg4[gi][gj]),
        .den     (den4[gi]),
        .quot    (q[gi][gj])
      );
    end
  end

  logic                cv   [DL];
  logic [2:0]          cpar [DL];
  logic [2:0]          crej [DL];
  logic signed [P-1:0] corg [DL][3];
  logic signed [D-1:0] cdir [DL][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) cv[k] <= 1'b0;
    end else if (en) begin
      cv[0] <= v4;
      for (int k = 1; k < DL; k++) cv[k] <= cv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpar[0] <= par4;
      crej[0] <= rej4;
      for (int c = 0; c < 3; c++) begin
        corg[0][c] <= org4[c];
        cdir[0][c] <= dir4[c];
      end
      for (int k = 1; k < DL; k++) begin
        cpar[k] <= cpar[k-1];
        crej[k] <= crej[k-1];
        for (int c = 0; c < 3; c++) begin
          corg[k][c] <= corg[k-1][c];
          cdir[k][c] <= cdir[k-1][c];
        end
      end
    end
  end

  // Entry and exit distances per axis, then the running narrowing over axes.
  logic                      va, vb, vc, vd;
  logic signed [T_WIDTH-1:0] lo_a [3], hi_a [3];
  logic [2:0]                sg_a, par_a, rej_a;
  logic signed [P-1:0]       org_a [3], org_b [3], org_c [3], org_d [3];
  logic signed [D-1:0]       dir_a [3], dir_b [3], dir_c [3];

  logic signed [T_WIDTH-1:0] tmin, tmax;
  logic [1:0]                minax, maxax;
  logic                      minneg, maxneg, hit_n;

  always_comb begin
    tmin   = -T_OPEN;
    tmax   = T_OPEN;
    minax  = AX_NONE;
    maxax  = AX_NONE;
    minneg = 1'b0;
    maxneg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!par_a[i]) begin
        if (lo_a[i] > tmin) begin
          tmin   = lo_a[i];
          minax  = 2'(i);
          minneg = sg_a[i];
        end
        if (hi_a[i] < tmax) begin
          tmax   = hi_a[i];
          maxax  = 2'(i);
          maxneg = !sg_a[i];
        end
      end
    end
    hit_n = !(|rej_a) && !(tmin > tmax) && !(tmax < 0);
  end

  logic signed [T_WIDTH-1:0] tmin_b, tmax_b;
  logic [1:0]                minax_b, maxax_b;
  logic                      minneg_b, maxneg_b, hit_b;

  logic signed [T_WIDTH-1:0] dsel;
  logic [1:0]                nax;
  logic                      nneg;
  logic [31:0]               dclamp;
  logic signed [D-1:0]       nsel [3];
  logic signed [D-1:0]       nval [3];

  always_comb begin
    if (tmin_b > 0) begin
      dsel = tmin_b;
      nax  = minax_b;
      nneg = minneg_b;
    end else begin
      dsel = tmax_b;
      nax  = maxax_b;
      nneg = maxneg_b;
    end
    if (dsel > $signed({17'd0, DIST_MAX})) dclamp = DIST_MAX;
    else if (dsel < 0) dclamp = '0;
    else dclamp = dsel[31:0];
    for (int c = 0; c < 3; c++) begin
      case (nax)
        2'd0:    nsel[c] = ax[0][c];
        2'd1:    nsel[c] = ax[1][c];
        2'd2:    nsel[c] = ax[2][c];
        default: nsel[c] = '0;
      endcase
      if (!hit_b || nax == AX_NONE) nval[c] = '0;
      else if (!nneg) nval[c] = nsel[c];
      else if (nsel[c] == DMIN) nval[c] = DMAXV;
      else nval[c] = -nsel[c];
    end
  end

  logic                hit_c, hit_d;
  logic [31:0]         dist_c, dist_d;
  logic signed [D-1:0] nrm_c [3], nrm_d [3];
  logic signed [PW-1:0] prod_d [3];

  logic signed [SW-1:0] psum [3];
  logic signed [P-1:0]  psat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      psum[c] = SW'(org_d[c]) + SW'(prod_d[c] >>> TS);
      if (!hit_d) psat[c] = '0;
      else if (psum[c] > PMAX) psat[c] = PMAX[P-1:0];
      else if (psum[c] < PMIN) psat[c] = PMIN[P-1:0];
      else psat[c] = psum[c][P-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc    <= 1'b0;
      vd    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      va    <= cv[DL-1];
      vb    <= va;
      vc    <= vb;
      vd    <= vc;
      v_out <= vd;
    end
  end

  logic                o_hit;
  logic [31:0]         o_dist;
  logic signed [D-1:0] o_nrm [3];
  logic signed [P-1:0] o_pt [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (q[i][0] > q[i][1]) begin
          lo_a[i] <= q[i][1];
          hi_a[i] <= q[i][0];
          sg_a[i] <= 1'b1;
        end else begin
          lo_a[i] <= q[i][0];
          hi_a[i] <= q[i][1];
          sg_a[i] <= 1'b0;
        end
      end
      par_a <= cpar[DL-1];
      rej_a <= crej[DL-1];

      tmin_b   <= tmin;
      tmax_b   <= tmax;
      minax_b  <= minax;
      maxax_b  <= maxax;
      minneg_b <= minneg;
      maxneg_b <= maxneg;
      hit_b    <= hit_n;

      hit_c  <= hit_b;
      dist_c <= hit_b ? dclamp : '0;

      hit_d  <= hit_c;
      dist_d <= dist_c;

      o_hit  <= hit_d;
      o_dist <= dist_d;

      for (int c = 0; c < 3; c++) begin
        org_a[c]  <= corg[DL-1][c];
        dir_a[c]  <= cdir[DL-1][c];
        org_b[c]  <= org_a[c];
        dir_b[c]  <= dir_a[c];
        org_c[c]  <= org_b[c];
        dir_c[c]  <= dir_b[c];
        nrm_c[c]  <= nval[c];
        org_d[c]  <= org_c[c];
        nrm_d[c]  <= nrm_c[c];
        prod_d[c] <= $signed({1'b0, dist_c}) * dir_c[c];
        o_nrm[c]  <= nrm_d[c];
        o_pt[c]   <= psat[c];
      end
    end
  end

  assign hit_out.valid        = v_out;
  assign hit_out.hit          = o_hit;
  assign hit_out.hit_distance = o_dist;
  assign hit_out.normal_x     = o_nrm[0];
  assign hit_out.normal_y     = o_nrm[1];
  assign hit_out.normal_z     = o_nrm[2];
  assign hit_out.point_x      = o_pt[0];
  assign hit_out.point_y      = o_pt[1];
  assign hit_out.point_z      = o_pt[2];

endmodule

[dv/tb.sv]
module tb;
  import robs_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int DW = DIR_WIDTH_DEF;
  localparam int CW = (3*PW > 3*DW) ? 3*PW : 3*DW;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct {
    logic signed [PW-1:0] org [3];
    logic signed [DW-1:0] dir [3];
  } ray_t;

  typedef struct {
    logic                 hit;
    logic [31:0]          distance;
    logic signed [DW-1:0] nrm [3];
    logic signed [PW-1:0] pnt [3];
  } hit_t;

  class box_scoreboard;
    logic [CW-1:0] center, half;
    logic [CW-1:0] axis [3];
    hit_t pending [$];
    int mismatches;
    int rays;
    int hits;
    int results;

    function new();
      center = '0;
      axis[0] = CW'(16384);
      axis[1] = CW'(16384) << DW;
      axis[2] = CW'(16384) << (2*DW);
      half = (CW'(4096) << (2*PW)) | (CW'(4096) << PW) | CW'(4096);
      mismatches = 0;
      rays = 0;
      hits = 0;
      results = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
      case (idx)
        REG_CENTER:     center = val & CW'({(3*PW){1'b1}});
        REG_AXIS_ONE:   axis[0] = val & CW'({(3*DW){1'b1}});
        REG_AXIS_TWO:   axis[1] = val & CW'({(3*DW){1'b1}});
        REG_AXIS_THREE: axis[2] = val & CW'({(3*DW){1'b1}});
        REG_HALF:       half = val & CW'({(3*PW){1'b1}});
        default: ;
      endcase
    endfunction

    function longint signext(longint unsigned v, int w);
      longint unsigned m;
      m = (64'd1 << w) - 64'd1;
      v = v & m;
      if (v[w-1]) return longint'(v) - (longint'(1) << w);
      return longint'(v);
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w-1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint slab_quotient(longint num, longint den);
      longint unsigned n, d, q, r, r2;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? longint'(0) - num : num;
      d = (den < 0) ? longint'(0) - den : den;
      q = n / d;
      r = n % d;
      for (int i = 0; i < 16 + (DW-2) - (PW-8) && q < T_CAP; i++) begin
        r2 = r << 1;
        q = (q << 1) | ((r2 >= d) ? 64'd1 : 64'd0);
        r = (r2 >= d) ? r2 - d : r2;
      end
      if (q > T_CAP) q = T_CAP;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function hit_t trace(ray_t rq);
      hit_t res;
      longint o [3], dv [3], off [3], ax [3][3];
      longint tmin, tmax, t_hit, e, f, h, t1, t2, tt, nv, pv, eps;
      int min_ax, max_ax, min_s, max_s, n_ax, n_s, s;
      res.hit = 1'b0;
      res.distance = '0;
      for (int c = 0; c < 3; c++) begin
        res.nrm[c] = '0;
        res.pnt[c] = '0;
      end
      eps = longint'(1) << (2*(DW-2) - 16);
      tmin = -(longint'(T_CAP) + 1);
      tmax = longint'(T_CAP) + 1;
      min_ax = -1;
      max_ax = -1;
      min_s = 1;
      max_s = 1;
      for (int c = 0; c < 3; c++) begin
        o[c] = longint'(rq.org[c]);
        dv[c] = longint'(rq.dir[c]);
        off[c] = signext(center >> (c*PW), PW) - o[c];
        for (int i = 0; i < 3; i++) ax[i][c] = signext(axis[i] >> (c*DW), DW);
      end
      for (int i = 0; i < 3; i++) begin
        e = 0;
        f = 0;
        for (int c = 0; c < 3; c++) begin
          e += ax[i][c] * off[c];
          f += ax[i][c] * dv[c];
        end
        h = longint'((half >> (i*PW)) & ((60'd1 << PW) - 60'd1)) << (DW-2);
        if (f > eps || f < -eps) begin
          t1 = slab_quotient(e + h, f);
          t2 = slab_quotient(e - h, f);
          s = 1;
          if (t1 > t2) begin
            tt = t1;
            t1 = t2;
            t2 = tt;
            s = -1;
          end
          if (t1 > tmin) begin
            tmin = t1;
            min_ax = i;
            min_s = s;
          end
          if (t2 < tmax) begin
            tmax = t2;
            max_ax = i;
            max_s = -s;
          end
          if (tmin > tmax || tmax < 0) return res;
        end else if (e < -h || e > h) begin
          return res;
        end
      end
      if (tmin > 0) begin
        t_hit = tmin;
        n_ax = min_ax;
        n_s = min_s;
      end else begin
        t_hit = tmax;
        n_ax = max_ax;
        n_s = max_s;
      end
      if (t_hit > longint'(DIST_MAX)) t_hit = longint'(DIST_MAX);
      if (t_hit < 0) t_hit = 0;
      res.hit = 1'b1;
      res.distance = t_hit[31:0];
      for (int c = 0; c < 3; c++) begin
        nv = 0;
        if (n_ax >= 0) nv = clamp((n_s < 0) ? -ax[n_ax][c] : ax[n_ax][c], DW);
        res.nrm[c] = nv[DW-1:0];
        pv = o[c] + ((t_hit * dv[c]) >>> (16 + (DW-2) - (PW-8)));
        pv = clamp(pv, PW);
        res.pnt[c] = pv[PW-1:0];
      end
      return res;
    endfunction

    function void note_ray(ray_t rq);
      hit_t r;
      r = trace(rq);
      rays++;
      if (r.hit) hits++;
      pending.push_back(r);
    endfunction

    function void check_hit(hit_t got);
      hit_t w;
      bit bad;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: hit %0b dist %h", got.hit, got.distance);
        return;
      end
      w = pending.pop_front();
      bad = (got.hit !== w.hit) || (got.distance !== w.distance);
      for (int c = 0; c < 3; c++)
        if (got.nrm[c] !== w.nrm[c] || got.pnt[c] !== w.pnt[c]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected hit %0b dist %h n %0d %0d %0d p %0d %0d %0d",
                   w.hit, w.distance, w.nrm[0], w.nrm[1], w.nrm[2],
                   w.pnt[0], w.pnt[1], w.pnt[2]);
          $display("          actual   hit %0b dist %h n %0d %0d %0d p %0d %0d %0d",
                   got.hit, got.distance, got.nrm[0], got.nrm[1], got.nrm[2],
                   got.pnt[0], got.pnt[1], got.pnt[2]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  robs_ray_if ray_bus ();
  robs_hit_if hit_bus ();

  ray_oriented_box_slab_test DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .ray(ray_bus),
    .hit_out(hit_bus)
  );

  box_scoreboard sb;
  int src_idle;
  int snk_idle;
  int hold_request;
  int hold_left;
  int cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    hit_t got;
    if (rst) begin
      hit_bus.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hit_bus.valid && hit_bus.ready) begin
        got.hit = hit_bus.hit;
        got.distance = hit_bus.hit_distance;
        got.nrm[0] = hit_bus.normal_x;
        got.nrm[1] = hit_bus.normal_y;
        got.nrm[2] = hit_bus.normal_z;
        got.pnt[0] = hit_bus.point_x;
        got.pnt[1] = hit_bus.point_y;
        got.pnt[2] = hit_bus.point_z;
        sb.check_hit(got);
      end
      if (hold_left > 0) begin
        hit_bus.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_request > 0) begin
        hit_bus.ready <= 1'b0;
        hold_left <= hold_request;
        hold_request = 0;
      end else begin
        hit_bus.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic send_ray(ray_t rq);
    if ($urandom_range(99) < src_idle) begin
      ray_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    ray_bus.valid <= 1'b1;
    ray_bus.ray_origin_x <= rq.org[0];
    ray_bus.ray_origin_y <= rq.org[1];
    ray_bus.ray_origin_z <= rq.org[2];
    ray_bus.ray_dir_x <= rq.dir[0];
    ray_bus.ray_dir_y <= rq.dir[1];
    ray_bus.ray_dir_z <= rq.dir[2];
    do @(posedge clk); while (!ray_bus.ready);
    sb.note_ray(rq);
  endtask

  task automatic drain();
    ray_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
    ray_t r;
    r.org[0] = PW'(ox);
    r.org[1] = PW'(oy);
    r.org[2] = PW'(oz);
    r.dir[0] = DW'(dx);
    r.dir[1] = DW'(dy);
    r.dir[2] = DW'(dz);
    return r;
  endfunction

  function automatic ray_t aimed_ray();
    ray_t r;
    longint c, o, d;
    int sh;
    sh = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      c = sb.signext(sb.center >> (k*PW), PW);
      o = c + $signed($urandom_range(32768)) - 16384;
      if ($urandom_range(7) == 0) o = c + $signed($urandom_range(2000)) - 1000;
      o = sb.clamp(o, PW);
      d = ((c - o) >>> sh) + $signed($urandom_range(2048)) - 1024;
      if ($urandom_range(9) == 0) d = 0;
      r.org[k] = PW'(o);
      r.dir[k] = DW'(sb.clamp(d, DW));
    end
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    for (int k = 0; k < 3; k++) begin
      r.org[k] = PW'($urandom());
      r.dir[k] = DW'($urandom());
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] pack_dir(int a, int b, int c);
    logic [DW-1:0] fa, fb, fc;
    fa = DW'(a);
    fb = DW'(b);
    fc = DW'(c);
    return CW'({fc, fb, fa});
  endfunction

  function automatic logic [CW-1:0] pack_pos(longint a, longint b, longint c);
    logic [PW-1:0] fa, fb, fc;
    fa = PW'(a);
    fb = PW'(b);
    fc = PW'(c);
    return CW'({fc, fb, fa});
  endfunction

  task automatic load_box(int kind);
    int s0, s1, s2, p;
    s0 = $urandom_range(1) ? 16384 : -16384;
    s1 = $urandom_range(1) ? 16384 : -16384;
    s2 = $urandom_range(1) ? 16384 : -16384;
    p = $urandom_range(2);
    case (kind)
      0: begin
        write_reg(REG_CENTER, pack_pos(524287, -524288, 0));
        write_reg(REG_AXIS_ONE, pack_dir(-32768, 0, 0));
        write_reg(REG_AXIS_TWO, pack_dir(0, 32767, 0));
        write_reg(REG_AXIS_THREE, pack_dir(0, 0, -32768));
        write_reg(REG_HALF, pack_pos(20'hFFFFF, 0, 20'hFFFFF));
      end
      1: begin
        write_reg(REG_CENTER, pack_pos($signed($urandom_range(16384)) - 8192,
                                       $signed($urandom_range(16384)) - 8192,
                                       $signed($urandom_range(16384)) - 8192));
        write_reg(REG_AXIS_ONE, pack_dir(11585, 11585, 0));
        write_reg(REG_AXIS_TWO, pack_dir(-11585, 11585, 0));
        write_reg(REG_AXIS_THREE, pack_dir(0, 0, s2));
        write_reg(REG_HALF, pack_pos($urandom_range(16384), $urandom_range(16384),
                                     $urandom_range(16384)));
      end
      default: begin
        write_reg(REG_CENTER, pack_pos($signed($urandom_range(20000)) - 10000,
                                       $signed($urandom_range(20000)) - 10000,
                                       $signed($urandom_range(20000)) - 10000));
        write_reg(REG_AXIS_ONE, (p == 0) ? pack_dir(s0, 0, 0) : pack_dir(0, s0, 0));
        write_reg(REG_AXIS_TWO, (p == 0) ? pack_dir(0, s1, 0) : pack_dir(s1, 0, 0));
        write_reg(REG_AXIS_THREE, (p == 2) ? pack_dir($urandom(), $urandom(), $urandom())
                                           : pack_dir(0, 0, s2));
        write_reg(REG_HALF, pack_pos($urandom_range(12000), $urandom_range(12000),
                                     (p == 1) ? 0 : $urandom_range(12000)));
      end
    endcase
    write_reg(3'd7, {CW{1'b1}});
    cfg_write <= 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_request = 0;
    src_idle = 0;
    snk_idle = 0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    ray_bus.valid <= 1'b0;
    ray_bus.ray_origin_x <= '0;
    ray_bus.ray_origin_y <= '0;
    ray_bus.ray_origin_z <= '0;
    ray_bus.ray_dir_x <= '0;
    ray_bus.ray_dir_y <= '0;
    ray_bus.ray_dir_z <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The unit cube left by reset: entry from outside, start inside, box behind,
    // parallel rays inside and outside, a zero direction and the field extremes.
    send_ray(make_ray(-8192, 0, 0, 16384, 0, 0));
    send_ray(make_ray(8192, 0, 0, -16384, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 16384, 0));
    send_ray(make_ray(0, 0, -12288, 0, 0, -16384));
    send_ray(make_ray(0, 8192, 0, 16384, 0, 0));
    send_ray(make_ray(-8192, 2048, 0, 16384, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, 1, -1, 0));
    send_ray(make_ray(-4096, 0, 0, 16384, 0, 0));
    send_ray(make_ray(-8192, -8192, -8192, 16384, 16384, 16384));
    send_ray(make_ray(-524288, -524288, -524288, 32767, 32767, 32767));
    send_ray(make_ray(524287, 524287, 524287, -32768, -32768, -32768));
    send_ray(make_ray(-524288, 0, 0, 1, 0, 0));
    send_ray(make_ray(0, 524287, 0, 0, -32768, 0));
    send_ray(make_ray(-8192, 0, 0, 16384, 4096, -4096));
    send_ray(make_ray(-4096, -4096, 0, 16384, 16384, 0));
    drain();
    load_box(0);
    send_ray(make_ray(0, 0, 0, 16384, 0, 0));
    send_ray(make_ray(524287, -524288, 0, 0, 0, 16384));
    send_ray(make_ray(-524288, 524287, 0, 32767, -32768, 0));
    send_ray(make_ray(0, -524288, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      src_idle = (ph < 2) ? 15 : (ph < 4) ? 56 : 0;
      snk_idle = (ph < 2) ? 56 : (ph < 4) ? 15 : 0;
      load_box(ph == 3 ? 0 : ph % 3);
      if (ph == 4) hold_request = 400;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_ray(($urandom_range(99) < 75) ? aimed_ray() : noise_ray());
      drain();
    end

    $display("rays traced: %0d, hits: %0d, result words checked: %0d",
             sb.rays, sb.hits, sb.results);
    $display("boxes covered: reset cube, axis-aligned, rotated and extreme registers");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("mismatch count: %0d", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/robs_pkg.sv
rtl/core/robs_if.sv
rtl/core/robs_slab_div.sv
rtl/core/ray_oriented_box_slab_test.sv
dv/tb.sv
